@@ sv/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ sv/umqrs_pkg.sv @@
// Types and constants for the uniform mod-q rejection sampler.
package umqrs_pkg;

	localparam int WORD_BITS  = 64;
	localparam int STEP_CNT_W = 6;
	localparam int MOD_IDX_W  = 3;
	localparam int COUNT_W    = 3;
	localparam int LOGD_W     = 5;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = 6;
	localparam int APB_DATA_W = 64;

	// register indexes (byte address = 8 * index)
	localparam logic [REG_IDX_W-1:0] REG_MODULUS_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOG_DEGREE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODULUS_0     = 3'd2;

	localparam logic [COUNT_W-1:0] RST_MODULUS_COUNT = 3'd1;
	localparam logic [LOGD_W-1:0]  RST_LOG_DEGREE    = 5'd12;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SETUP    = 6'b000010,
		ST_DIV_MAX  = 6'b000100,
		ST_CHECK    = 6'b001000,
		ST_DIV_WORD = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

endpackage

@@ sv/uniform_mod_q_rejection_sampler.sv @@
// Uniform mod-q rejection sampler: iterative shift-subtract remainder unit and row counters.
// One restoring remainder unit (one bit per cycle) does all division.
// Accepted word: its remainder mod q goes to the output register. (2^64-1) mod q is cached per
// row and recomputed first after any config write or row change. Rejected word: no output;
// the unit returns to idle for the next input. One word in flight; a result waits in the
// output register while the next is taken. arst_n resets FSM, counters, cache and config.
module uniform_mod_q_rejection_sampler #(
	parameter int MAX_MODULI     = 6,
	parameter int MAX_LOG_DEGREE = 16,
	parameter int MODULUS_BITS   = 61
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	input  logic [umqrs_pkg::WORD_BITS-1:0]              s_tdata,  // random_word
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// coefficient, modulus_index, coeff_index, zero pad to bytes
	output logic [((MODULUS_BITS+umqrs_pkg::MOD_IDX_W+MAX_LOG_DEGREE+7)/8)*8-1:0] m_tdata,
	output logic                                         m_tlast,  // last_of_poly
	input  logic                                         psel,
	input  logic                                         penable,
	input  logic                                         pwrite,
	input  logic [umqrs_pkg::PADDR_W-1:0]                paddr,
	input  logic [umqrs_pkg::APB_DATA_W-1:0]             pwdata,
	output logic [umqrs_pkg::APB_DATA_W-1:0]             prdata,
	output logic                                         pready
);
	import umqrs_pkg::*;

	localparam int TDATA_W = ((MODULUS_BITS + MOD_IDX_W + MAX_LOG_DEGREE + 7) / 8) * 8;
	localparam int MI_W    = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;
	localparam int MB      = MODULUS_BITS;

	state_t                    state_q;
	logic [STEP_CNT_W-1:0]     cnt_q;
	logic [MOD_IDX_W-1:0]      mc_q;
	logic [MAX_LOG_DEGREE-1:0] cc_q;
	logic                      m_tvalid_q;
	logic                      rmax_ok_q;
	logic [MOD_IDX_W-1:0]      rmax_tag_q;

	logic [COUNT_W-1:0]        modulus_count_q;
	logic [LOGD_W-1:0]         log_degree_q;
	logic [MB-1:0]             moduli_q [MAX_MODULI];

	logic [WORD_BITS-1:0]      word_q;
	logic [WORD_BITS-1:0]      div_q;
	logic [MB-1:0]             rem_q;
	logic [MB-1:0]             q_q;
	logic [MB-1:0]             rmax_q;
	logic [MB-1:0]             out_coef_q;
	logic [MOD_IDX_W-1:0]      out_midx_q;
	logic [MAX_LOG_DEGREE-1:0] out_cidx_q;
	logic                      out_last_q;

	logic                      in_xfer;
	logic                      out_load;
	logic                      cfg_we;
	logic [REG_IDX_W-1:0]      reg_idx;
	logic                      reg_is_mod;
	logic [MI_W-1:0]           reg_mod_sel;
	logic [COUNT_W-1:0]        eff_cnt;
	logic [COUNT_W-1:0]        eff_cnt_m1;
	logic [LOGD_W-1:0]         eff_ld;
	logic [MAX_LOG_DEGREE-1:0] deg_mask;
	logic                      out_of_bounds;
	logic [MB-1:0]             q_raw;
	logic [MB-1:0]             q_sel;
	logic                      cache_hit;
	logic [MB:0]               trial;
	logic [MB+1:0]             diff;
	logic [MB-1:0]             rem_next;
	logic                      div_last;
	logic [WORD_BITS+1:0]      thr_sum;
	logic                      reject;
	logic                      row_end;
	logic                      last_coef;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'({out_cidx_q, out_midx_q, out_coef_q});
	assign m_tlast  = out_last_q;
	assign pready   = 1'b1;

	// APB decode
	assign cfg_we      = psel && penable && pwrite && pready;
	assign reg_idx     = paddr[PADDR_W-1:3];
	assign reg_is_mod  = (reg_idx >= REG_MODULUS_0) &&
	                     ((reg_idx - REG_MODULUS_0) < REG_IDX_W'(MAX_MODULI));
	assign reg_mod_sel = MI_W'(reg_idx - REG_MODULUS_0);

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MODULUS_COUNT) begin
			prdata = APB_DATA_W'(modulus_count_q);
		end else if (reg_idx == REG_LOG_DEGREE) begin
			prdata = APB_DATA_W'(log_degree_q);
		end else if (reg_is_mod) begin
			prdata = APB_DATA_W'(moduli_q[reg_mod_sel]);
		end
	end

	// effective configuration
	always_comb begin
		eff_cnt = modulus_count_q;
		if (modulus_count_q == '0) begin
			eff_cnt = COUNT_W'(1);
		end else if (modulus_count_q > COUNT_W'(MAX_MODULI)) begin
			eff_cnt = COUNT_W'(MAX_MODULI);
		end
		eff_ld = log_degree_q;
		if (log_degree_q == '0) begin
			eff_ld = LOGD_W'(1);
		end else if (log_degree_q > LOGD_W'(MAX_LOG_DEGREE)) begin
			eff_ld = LOGD_W'(MAX_LOG_DEGREE);
		end
	end

	assign eff_cnt_m1    = eff_cnt - COUNT_W'(1);
	assign deg_mask      = ~({MAX_LOG_DEGREE{1'b1}} << eff_ld);
	assign out_of_bounds = (mc_q >= eff_cnt) || (cc_q > deg_mask);

	assign q_raw     = moduli_q[mc_q[MI_W-1:0]];
	assign q_sel     = (q_raw < MB'(2)) ? MB'(2) : q_raw;
	assign cache_hit = rmax_ok_q && (rmax_tag_q == mc_q);

	// restoring remainder step: one dividend bit per cycle
	assign trial    = {rem_q, div_q[WORD_BITS-1]};
	assign diff     = {1'b0, trial} - {2'b00, q_q};
	assign rem_next = diff[MB+1] ? trial[MB-1:0] : diff[MB-1:0];
	assign div_last = (cnt_q == '1);

	// word >= 2^64-1 - r - 1  <=>  word + r + 2 carries out of 64 bits
	assign thr_sum = {2'b00, word_q} + (WORD_BITS+2)'(rmax_q) + (WORD_BITS+2)'(2);
	assign reject  = |thr_sum[WORD_BITS+1:WORD_BITS];

	assign row_end   = (cc_q == deg_mask);
	assign last_coef = row_end && (mc_q == eff_cnt_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			mc_q            <= '0;
			cc_q            <= '0;
			m_tvalid_q      <= 1'b0;
			rmax_ok_q       <= 1'b0;
			rmax_tag_q      <= '0;
			modulus_count_q <= RST_MODULUS_COUNT;
			log_degree_q    <= RST_LOG_DEGREE;
			for (int i = 0; i < MAX_MODULI; i++) begin
				moduli_q[i] <= MB'(2);
			end
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (out_of_bounds) begin
							mc_q <= '0;
							cc_q <= '0;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q   <= '0;
					state_q <= cache_hit ? ST_CHECK : ST_DIV_MAX;
				end
				ST_DIV_MAX: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (div_last) begin
						rmax_ok_q  <= 1'b1;
						rmax_tag_q <= mc_q;
						state_q    <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q   <= '0;
					state_q <= reject ? ST_IDLE : ST_DIV_WORD;
				end
				ST_DIV_WORD: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						if (last_coef) begin
							mc_q <= '0;
							cc_q <= '0;
						end else if (row_end) begin
							mc_q <= mc_q + MOD_IDX_W'(1);
							cc_q <= '0;
						end else begin
							cc_q <= cc_q + MAX_LOG_DEGREE'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				rmax_ok_q <= 1'b0;
				if (reg_idx == REG_MODULUS_COUNT) begin
					modulus_count_q <= pwdata[COUNT_W-1:0];
				end else if (reg_idx == REG_LOG_DEGREE) begin
					log_degree_q <= pwdata[LOGD_W-1:0];
				end else if (reg_is_mod) begin
					moduli_q[reg_mod_sel] <= pwdata[MB-1:0];
				end
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			word_q <= s_tdata;
		end
		case (state_q)
			ST_SETUP: begin
				q_q   <= q_sel;
				div_q <= '1;
				rem_q <= '0;
			end
			ST_DIV_MAX: begin
				div_q <= div_q << 1;
				rem_q <= rem_next;
				if (div_last) begin
					rmax_q <= rem_next;
				end
			end
			ST_CHECK: begin
				div_q <= word_q;
				rem_q <= '0;
			end
			ST_DIV_WORD: begin
				div_q <= div_q << 1;
				rem_q <= rem_next;
			end
			ST_DONE: begin
				if (out_load) begin
					out_coef_q <= rem_q;
					out_midx_q <= mc_q;
					out_cidx_q <= cc_q;
					out_last_q <= last_coef;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/umqrs_checker.sv @@
// Port-level checks for the uniform mod-q rejection sampler, bound to the top level.
`include "assert_macros.svh"

module umqrs_checker #(
	parameter int MAX_MODULI     = 6,
	parameter int MAX_LOG_DEGREE = 16,
	parameter int MODULUS_BITS   = 61
) (
	input logic                                         clk,
	input logic                                         arst_n,
	input logic                                         s_tvalid,
	input logic                                         s_tready,
	input logic                                         m_tvalid,
	input logic                                         m_tready,
	input logic [((MODULUS_BITS+umqrs_pkg::MOD_IDX_W+MAX_LOG_DEGREE+7)/8)*8-1:0] m_tdata
);
	import umqrs_pkg::*;

	logic m_stall;
	logic in_xfer;
	logic mod_idx_ok;

	assign m_stall    = m_tvalid && !m_tready;
	assign in_xfer    = s_tvalid && s_tready;
	assign mod_idx_ok = m_tdata[MODULUS_BITS +: MOD_IDX_W] < MOD_IDX_W'(MAX_MODULI);

	`ASSERT_NEXT(a_out_valid_holds, clk, arst_n, m_stall, m_tvalid)
	`ASSERT_NEXT(a_out_data_holds, clk, arst_n, m_stall, $stable(m_tdata))
	// one word at a time: the unit is busy right after taking a word
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_xfer, !s_tready)
	// no result can come out of the remainder unit in the cycle after a transfer in
	`ASSERT_NEXT(a_no_instant_out, clk, arst_n, in_xfer, !$rose(m_tvalid))
	`ASSERT_IMPL(a_mod_idx_range, clk, arst_n, m_tvalid, mod_idx_ok)

endmodule

bind uniform_mod_q_rejection_sampler umqrs_checker #(
	.MAX_MODULI     (MAX_MODULI),
	.MAX_LOG_DEGREE (MAX_LOG_DEGREE),
	.MODULUS_BITS   (MODULUS_BITS)
) u_umqrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
